// ===== sv/quad_rotate_project_cull_top_macros.svh =====
// Assertion macros shared by the quad geometry block.
`ifndef QUAD_ROTATE_PROJECT_CULL_TOP_MACROS_SVH
`define QUAD_ROTATE_PROJECT_CULL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define QRPC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("qrpc assertion failed");
// Checked on every edge, reset included.
`define QRPC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("qrpc assertion failed");
`else
`define QRPC_ASSERT(lbl, prop)
`define QRPC_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/qrpc_pkg.sv =====
// Types, constants and arithmetic helpers of the quad geometry block.
`timescale 1ns / 1ps
package qrpc_pkg;

    localparam int SCREEN_FRAC_BITS = 4;
    localparam int FOCAL_Q16        = 45875;   // 0.7 in Q0.16

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MA_W   = 36;
    localparam int MB_W   = 19;
    localparam int PROD_W = MA_W + MB_W;
    localparam int ACC_W  = 56;
    localparam int DOT_W  = 57;

    // quotient bits kept before the screen value saturates anyway
    localparam int Q_BITS = 17 + SCREEN_FRAC_BITS;
    localparam int DIV_W  = 51;
    localparam int CNT_W  = $clog2(Q_BITS + 1);
    localparam int SUM_W  = Q_BITS + 2;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_RZ   = STEP_W'(7);
    localparam logic [STEP_W-1:0] STEP_NUMX = STEP_W'(9);
    localparam logic [STEP_W-1:0] STEP_NUMY = STEP_W'(11);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(20);

    localparam logic [1:0] CORNER_0 = 2'd0;
    localparam logic [1:0] CORNER_1 = 2'd1;
    localparam logic [1:0] CORNER_2 = 2'd2;
    localparam logic [1:0] CORNER_3 = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIN_YAW, CFG_COS_YAW, CFG_SIN_PITCH, CFG_COS_PITCH,
        CFG_SCREEN_W, CFG_SCREEN_H, CFG_CAM_DIST, CFG_NEAR
    } t_cfg_idx;

    typedef enum logic [3:0] {
        A_NONE, A_PX, A_PY, A_PZ, A_Z1, A_RX, A_RY, A_ACC, A_UX, A_UY, A_UZ
    } t_asel;

    typedef enum logic [3:0] {
        B_NONE, B_SY, B_CY, B_SP, B_CP, B_H, B_FOC, B_VX, B_VY, B_VZ,
        B_EX, B_EY, B_EZ
    } t_bsel;

    typedef enum logic [2:0] {OP_SET, OP_ADD, OP_SUB, OP_DSET, OP_DADD, OP_HOLD} t_accop;
    typedef enum logic [2:0] {D_NONE, D_RX, D_Z1, D_RY, D_RZ} t_dst;

    typedef struct packed {
        t_asel  a;
        t_bsel  b;
        t_accop op;
        t_dst   dst;
    } t_ucode;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_ACC, S_NEAR, S_DIV, S_FIN, S_EMIT0, S_EMIT1
    } t_state;

    typedef struct packed {
        logic   load;
        logic   mul;
        logic   acc;
        t_ucode uc;
        logic   div_start;
        logic   div_step;
        logic   store_qx;
        logic   store_qy;
        logic   commit;
        logic   emit;
        logic   second;
    } t_cmd;

    typedef struct packed {
        logic [1:0] corner;
        logic       near_ok;
        logic       div_done;
        logic       face_ok;
        logic       out_free;
    } t_sts;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [1:0]         corner;
        logic [7:0]         face_shade;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] tri_ax;
        logic signed [15:0] tri_ay;
        logic signed [15:0] tri_bx;
        logic signed [15:0] tri_by;
        logic signed [15:0] tri_cx;
        logic signed [15:0] tri_cy;
        logic               second_triangle;
        logic [7:0]         shade_out;
        logic               last;
    } t_out_item;

    // Step program of the shared multiply-accumulate unit.
    function automatic t_ucode ucode(input logic [STEP_W-1:0] step);
        t_ucode u;
        u = '{a: A_NONE, b: B_NONE, op: OP_HOLD, dst: D_NONE};
        case (step)
            5'd0:  u = '{a: A_PX,  b: B_CY,  op: OP_SET,  dst: D_NONE};
            5'd1:  u = '{a: A_PZ,  b: B_SY,  op: OP_ADD,  dst: D_RX};
            5'd2:  u = '{a: A_PZ,  b: B_CY,  op: OP_SET,  dst: D_NONE};
            5'd3:  u = '{a: A_PX,  b: B_SY,  op: OP_SUB,  dst: D_Z1};
            5'd4:  u = '{a: A_PY,  b: B_CP,  op: OP_SET,  dst: D_NONE};
            5'd5:  u = '{a: A_Z1,  b: B_SP,  op: OP_SUB,  dst: D_RY};
            5'd6:  u = '{a: A_PY,  b: B_SP,  op: OP_SET,  dst: D_NONE};
            5'd7:  u = '{a: A_Z1,  b: B_CP,  op: OP_ADD,  dst: D_RZ};
            5'd8:  u = '{a: A_RX,  b: B_H,   op: OP_SET,  dst: D_NONE};
            5'd9:  u = '{a: A_ACC, b: B_FOC, op: OP_SET,  dst: D_NONE};
            5'd10: u = '{a: A_RY,  b: B_H,   op: OP_SET,  dst: D_NONE};
            5'd11: u = '{a: A_ACC, b: B_FOC, op: OP_SET,  dst: D_NONE};
            5'd12: u = '{a: A_UY,  b: B_VZ,  op: OP_SET,  dst: D_NONE};
            5'd13: u = '{a: A_UZ,  b: B_VY,  op: OP_SUB,  dst: D_NONE};
            5'd14: u = '{a: A_ACC, b: B_EX,  op: OP_DSET, dst: D_NONE};
            5'd15: u = '{a: A_UZ,  b: B_VX,  op: OP_SET,  dst: D_NONE};
            5'd16: u = '{a: A_UX,  b: B_VZ,  op: OP_SUB,  dst: D_NONE};
            5'd17: u = '{a: A_ACC, b: B_EY,  op: OP_DADD, dst: D_NONE};
            5'd18: u = '{a: A_UX,  b: B_VY,  op: OP_SET,  dst: D_NONE};
            5'd19: u = '{a: A_UY,  b: B_VX,  op: OP_SUB,  dst: D_NONE};
            5'd20: u = '{a: A_ACC, b: B_EZ,  op: OP_DADD, dst: D_NONE};
            default: u = '{a: A_NONE, b: B_NONE, op: OP_HOLD, dst: D_NONE};
        endcase
        return u;
    endfunction

    // Q1.14 product sum back to Q4.12: round half up, saturate.
    function automatic logic signed [15:0] round_q12(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        t = (v + ACC_W'(8192)) >>> 14;
        if (t > ACC_W'(32767)) return 16'sh7FFF;
        if (t < ACC_W'(-32768)) return 16'sh8000;
        return t[15:0];
    endfunction

    function automatic logic signed [15:0] sat_scr(input logic signed [SUM_W-1:0] v);
        if (v > SUM_W'(32767)) return 16'sh7FFF;
        if (v < SUM_W'(-32768)) return 16'sh8000;
        return v[15:0];
    endfunction

endpackage

// ===== sv/qrpc_in_if.sv =====
// Request channel carrying one face corner.
`timescale 1ns / 1ps
interface qrpc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [1:0]         corner;
    logic [7:0]         face_shade;

    modport source (output valid, pos_x, pos_y, pos_z, corner, face_shade, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, corner, face_shade, output ready);
endinterface

// ===== sv/qrpc_out_if.sv =====
// Result channel carrying one screen triangle.
`timescale 1ns / 1ps
interface qrpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] tri_ax;
    logic signed [15:0] tri_ay;
    logic signed [15:0] tri_bx;
    logic signed [15:0] tri_by;
    logic signed [15:0] tri_cx;
    logic signed [15:0] tri_cy;
    logic               second_triangle;
    logic [7:0]         shade_out;
    logic               last;

    modport source (output valid, tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy,
                    second_triangle, shade_out, last, input ready);
    modport sink   (input valid, tri_ax, tri_ay, tri_bx, tri_by, tri_cx, tri_cy,
                    second_triangle, shade_out, last, output ready);
endinterface

// ===== sv/quad_rotate_project_cull_top.sv =====
// Top level of the quad rotate, project and cull geometry stage.
// Sequence: accept, rotate, near test, project, commit; corner 2 adds the back-face test,
//   a near-rejected corner skips projection, and corner 3 then emits two requests through
//   the output register, each once it is free. No new request is taken until a corner is done,
//   since the shared 36x19 MAC and the 21-step serial divider serve one corner at a time.
// Reset: synchronous active low; controller, config defaults, shade, reject flag, output valid.
`timescale 1ns / 1ps
module quad_rotate_project_cull_top import qrpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    qrpc_in_if.sink               i_in,
    qrpc_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd      cmd;
    t_sts      sts;
    t_in_item  in_item;
    t_out_item out_item;
    logic      out_valid;

    // corner request payload gathered into one struct for the datapath
    assign in_item.pos_x      = i_in.pos_x;
    assign in_item.pos_y      = i_in.pos_y;
    assign in_item.pos_z      = i_in.pos_z;
    assign in_item.corner     = i_in.corner;
    assign in_item.face_shade = i_in.face_shade;

    qrpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qrpc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_item      (in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_out_item  (out_item)
    );

    // triangle request from the output register
    assign o_out.valid           = out_valid;
    assign o_out.tri_ax          = out_item.tri_ax;
    assign o_out.tri_ay          = out_item.tri_ay;
    assign o_out.tri_bx          = out_item.tri_bx;
    assign o_out.tri_by          = out_item.tri_by;
    assign o_out.tri_cx          = out_item.tri_cx;
    assign o_out.tri_cy          = out_item.tri_cy;
    assign o_out.second_triangle = out_item.second_triangle;
    assign o_out.shade_out       = out_item.shade_out;
    assign o_out.last            = out_item.last;

endmodule

// ===== sv/qrpc_datapath.sv =====
// Datapath: config registers, shared MAC, serial divider, corner store, output register.
`timescale 1ns / 1ps
module qrpc_datapath import qrpc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_item
);

    logic signed [15:0] r_sin_yaw, r_cos_yaw, r_sin_pitch, r_cos_pitch;
    logic [12:0]        r_scr_w, r_scr_h;
    logic [14:0]        r_cam, r_near;

    logic signed [15:0] r_px, r_py, r_pz;
    logic [1:0]         r_corner;
    logic [7:0]         r_shade_in;

    logic signed [15:0] r_rx, r_ry, r_rz, r_z1;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic signed [DOT_W-1:0]  r_dot, n_dot;

    logic [DIV_W-1:0]   r_rem, r_dsr;
    logic [Q_BITS-1:0]  r_q;
    logic [CNT_W-1:0]   r_div_cnt;
    logic               r_div_neg, r_div_ovf;
    logic signed [15:0] r_sx, r_sy;

    logic signed [15:0] r_rot_x [3];
    logic signed [15:0] r_rot_y [3];
    logic signed [15:0] r_rot_z [3];
    logic signed [15:0] r_scr_x [3];
    logic signed [15:0] r_scr_y [3];
    logic [7:0]         r_held_shade;
    logic               r_rej;

    logic               r_out_valid;
    t_out_item          r_out;

    // depth and near test
    logic signed [17:0] depth;
    logic               near_ok;
    assign depth   = 18'(r_rz) + $signed({3'b000, r_cam});
    assign near_ok = (depth >= $signed({3'b000, r_near})) && (depth > 18'sd0);

    // back-face edge vectors against stored corners 0 and 1
    logic signed [16:0] ux, uy, uz, vx, vy, vz, ex, ey;
    logic signed [18:0] ez;
    assign ux = 17'(r_rot_x[1]) - 17'(r_rot_x[0]);
    assign uy = 17'(r_rot_y[1]) - 17'(r_rot_y[0]);
    assign uz = 17'(r_rot_z[1]) - 17'(r_rot_z[0]);
    assign vx = 17'(r_rx) - 17'(r_rot_x[0]);
    assign vy = 17'(r_ry) - 17'(r_rot_y[0]);
    assign vz = 17'(r_rz) - 17'(r_rot_z[0]);
    assign ex = -17'(r_rot_x[0]);
    assign ey = -17'(r_rot_y[0]);
    assign ez = -(19'(r_rot_z[0]) + $signed({4'b0000, r_cam}));

    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;

    always_comb begin
        case (i_cmd.uc.a)
            A_PX:    mul_a = MA_W'(r_px);
            A_PY:    mul_a = MA_W'(r_py);
            A_PZ:    mul_a = MA_W'(r_pz);
            A_Z1:    mul_a = MA_W'(r_z1);
            A_RX:    mul_a = MA_W'(r_rx);
            A_RY:    mul_a = MA_W'(r_ry);
            A_ACC:   mul_a = r_acc[MA_W-1:0];
            A_UX:    mul_a = MA_W'(ux);
            A_UY:    mul_a = MA_W'(uy);
            A_UZ:    mul_a = MA_W'(uz);
            default: mul_a = '0;
        endcase
        case (i_cmd.uc.b)
            B_SY:    mul_b = MB_W'(r_sin_yaw);
            B_CY:    mul_b = MB_W'(r_cos_yaw);
            B_SP:    mul_b = MB_W'(r_sin_pitch);
            B_CP:    mul_b = MB_W'(r_cos_pitch);
            B_H:     mul_b = MB_W'({1'b0, r_scr_h});
            B_FOC:   mul_b = MB_W'(FOCAL_Q16);
            B_VX:    mul_b = MB_W'(vx);
            B_VY:    mul_b = MB_W'(vy);
            B_VZ:    mul_b = MB_W'(vz);
            B_EX:    mul_b = MB_W'(ex);
            B_EY:    mul_b = MB_W'(ey);
            B_EZ:    mul_b = ez;
            default: mul_b = '0;
        endcase
    end

    always_comb begin
        n_acc = r_acc;
        n_dot = r_dot;
        case (i_cmd.uc.op)
            OP_SET:  n_acc = ACC_W'(r_prod);
            OP_ADD:  n_acc = r_acc + ACC_W'(r_prod);
            OP_SUB:  n_acc = r_acc - ACC_W'(r_prod);
            OP_DSET: n_dot = DOT_W'(r_prod);
            OP_DADD: n_dot = r_dot + DOT_W'(r_prod);
            default: n_acc = r_acc;
        endcase
    end

    logic signed [15:0] rnd;
    assign rnd = round_q12(n_acc);

    // divider setup from the numerator being formed this cycle
    logic signed [ACC_W-1:0] abs_n;
    logic [DIV_W-1:0]        den, mr;
    assign abs_n = n_acc[ACC_W-1] ? -n_acc : n_acc;
    assign den   = DIV_W'(depth[16:0]) << (16 - SCREEN_FRAC_BITS);
    assign mr    = abs_n[DIV_W-1:0] + (den >> 1);

    logic [Q_BITS-1:0]         qv;
    logic signed [Q_BITS:0]    qs;
    logic [SUM_W-1:0]          half_w, half_h;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    assign qv     = r_div_ovf ? '1 : r_q;
    assign qs     = r_div_neg ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
    assign half_w = (SUM_W'(r_scr_w) << SCREEN_FRAC_BITS) >> 1;
    assign half_h = (SUM_W'(r_scr_h) << SCREEN_FRAC_BITS) >> 1;
    assign sum_x  = $signed(half_w) + SUM_W'(qs);
    assign sum_y  = $signed(half_h) - SUM_W'(qs);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_yaw   <= 16'sd0;
            r_cos_yaw   <= 16'sd16384;
            r_sin_pitch <= 16'sd0;
            r_cos_pitch <= 16'sd16384;
            r_scr_w     <= 13'd800;
            r_scr_h     <= 13'd560;
            r_cam       <= 15'd13107;
            r_near      <= 15'd819;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SIN_YAW:   r_sin_yaw   <= i_cfg_data;
                CFG_COS_YAW:   r_cos_yaw   <= i_cfg_data;
                CFG_SIN_PITCH: r_sin_pitch <= i_cfg_data;
                CFG_COS_PITCH: r_cos_pitch <= i_cfg_data;
                CFG_SCREEN_W:  r_scr_w     <= i_cfg_data[12:0];
                CFG_SCREEN_H:  r_scr_h     <= i_cfg_data[12:0];
                CFG_CAM_DIST:  r_cam       <= i_cfg_data[14:0];
                CFG_NEAR:      r_near      <= i_cfg_data[14:0];
                default:       r_near      <= r_near;
            endcase
        end
    end

    // arithmetic payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px       <= i_item.pos_x;
            r_py       <= i_item.pos_y;
            r_pz       <= i_item.pos_z;
            r_corner   <= i_item.corner;
            r_shade_in <= i_item.face_shade;
        end
        if (i_cmd.mul) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.acc) begin
            r_acc <= n_acc;
            r_dot <= n_dot;
            case (i_cmd.uc.dst)
                D_RX:    r_rx <= rnd;
                D_Z1:    r_z1 <= rnd;
                D_RY:    r_ry <= rnd;
                D_RZ:    r_rz <= rnd;
                default: r_rx <= r_rx;
            endcase
        end
        if (i_cmd.div_start) begin
            r_rem     <= mr;
            r_dsr     <= den << (Q_BITS - 1);
            r_q       <= '0;
            r_div_neg <= n_acc[ACC_W-1];
            r_div_ovf <= mr >= (den << Q_BITS);
        end else if (i_cmd.div_step) begin
            if (r_rem >= r_dsr) begin
                r_rem <= r_rem - r_dsr;
                r_q   <= {r_q[Q_BITS-2:0], 1'b1};
            end else begin
                r_q   <= {r_q[Q_BITS-2:0], 1'b0};
            end
            r_dsr <= r_dsr >> 1;
        end
        if (i_cmd.store_qx) r_sx <= sat_scr(sum_x);
        if (i_cmd.store_qy) r_sy <= sat_scr(sum_y);
        if (i_cmd.commit && r_corner != CORNER_3) begin
            r_rot_x[r_corner] <= r_rx;
            r_rot_y[r_corner] <= r_ry;
            r_rot_z[r_corner] <= r_rz;
            r_scr_x[r_corner] <= near_ok ? r_sx : 16'sd0;
            r_scr_y[r_corner] <= near_ok ? r_sy : 16'sd0;
        end
        if (i_cmd.emit) begin
            r_out.tri_ax          <= r_scr_x[0];
            r_out.tri_ay          <= r_scr_y[0];
            r_out.tri_bx          <= i_cmd.second ? r_scr_x[2] : r_scr_x[1];
            r_out.tri_by          <= i_cmd.second ? r_scr_y[2] : r_scr_y[1];
            r_out.tri_cx          <= i_cmd.second ? r_sx : r_scr_x[2];
            r_out.tri_cy          <= i_cmd.second ? r_sy : r_scr_y[2];
            r_out.second_triangle <= i_cmd.second;
            r_out.shade_out       <= r_held_shade;
            r_out.last            <= i_cmd.second;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt    <= '0;
            r_held_shade <= '0;
            r_rej        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.div_start) begin
                r_div_cnt <= CNT_W'(Q_BITS);
            end else if (i_cmd.div_step && r_div_cnt != '0) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
            if (i_cmd.commit) begin
                case (r_corner)
                    CORNER_0: begin
                        r_held_shade <= r_shade_in;
                        r_rej        <= !near_ok;
                    end
                    CORNER_1: r_rej <= r_rej || !near_ok;
                    CORNER_2: r_rej <= r_rej || !near_ok || !(r_dot > DOT_W'(0));
                    default:  r_rej <= r_rej;
                endcase
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.corner   = r_corner;
    assign o_sts.near_ok  = near_ok;
    assign o_sts.div_done = (r_div_cnt == '0);
    assign o_sts.face_ok  = !r_rej && near_ok;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sv/qrpc_ctrl.sv =====
// Controller: sequences MAC steps, divisions, commit and triangle emission.
`timescale 1ns / 1ps
`include "quad_rotate_project_cull_top_macros.svh"
module qrpc_ctrl import qrpc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.uc   = ucode(r_step);
        case (r_state)
            S_IDLE: begin
                // no request is taken while reset is held
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_step == STEP_RZ) begin
                    n_state = S_NEAR;
                end else if (r_step == STEP_NUMX || r_step == STEP_NUMY) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else if (r_step == STEP_LAST) begin
                    n_state = S_FIN;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_NEAR: begin
                // a corner in front of the near plane skips projection
                if (i_sts.near_ok) begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MUL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    if (r_step == STEP_NUMX) begin
                        o_cmd.store_qx = 1'b1;
                        n_step         = r_step + 1'b1;
                        n_state        = S_MUL;
                    end else begin
                        o_cmd.store_qy = 1'b1;
                        if (i_sts.corner == CORNER_2) begin
                            n_step  = r_step + 1'b1;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.commit = 1'b1;
                if (i_sts.corner == CORNER_3 && i_sts.face_ok) begin
                    n_state = S_EMIT0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT0: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_EMIT1;
                end
            end
            S_EMIT1: begin
                if (i_sts.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.second = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `QRPC_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> (r_state == S_IDLE))
    `QRPC_ASSERT(a_accept_starts, (r_state == S_IDLE && i_in_valid) |=> (r_state == S_MUL && r_step == '0))
    `QRPC_ASSERT(a_div_steps, (r_state == S_DIV) |-> (r_step == STEP_NUMX || r_step == STEP_NUMY))
    `QRPC_ASSERT(a_emit_corner3, (r_state == S_EMIT0 || r_state == S_EMIT1) |-> (i_sts.corner == CORNER_3))

endmodule
